### sv/tlb_pkg.sv
// ----------------------------------------------------------------------------
// Terminal line buffer package
// Shared request and result types, action codes and character codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tlb_pkg;

  localparam int DEFAULT_DEPTH = 64;

  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_READ   = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  localparam logic [7:0] CH_BACKSPACE  = 8'h08;
  localparam logic [7:0] CH_RETURN     = 8'h0D;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_TERMINATOR = 8'h00;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] char_in;
    logic [5:0] read_index;
  } req_t;

  typedef struct packed {
    logic       status;
    logic       line_ready;
    logic       read_found;
    logic [7:0] read_byte;
    logic [6:0] fill_count;
  } res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_BKSP
  } state_t;

endpackage

`default_nettype wire

### sv/terminal_line_buffer.sv
// ----------------------------------------------------------------------------
// Terminal line buffer
// Line editing store for terminal characters with backspace and line reads.
// ----------------------------------------------------------------------------
// Append of a data byte, carriage return, newline, clear and the unused
// action code each register their result straight from the request. A read and a
// backspace that removes a byte first pass through the S_READ or S_BKSP state,
// since both wait on the synchronous read of the character memory. One request is
// in flight at a time; a new request is taken while the output register is empty
// or its previous result is being taken.
`timescale 1ns / 1ps
`default_nettype none

module terminal_line_buffer #(
  parameter int BUFFER_DEPTH = tlb_pkg::DEFAULT_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire tlb_pkg::req_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output tlb_pkg::res_t      out_data
);

  localparam int AW   = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CNTW = $clog2(BUFFER_DEPTH + 1);
  localparam int XW   = (CNTW > 6) ? CNTW : 6;

  logic [7:0] mem [BUFFER_DEPTH];
  logic [7:0] rdata_r;

  tlb_pkg::state_t state_r, state_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic            lz_r, lz_nxt;
  logic            found_r, found_nxt;
  logic            out_valid_r, out_valid_nxt;
  tlb_pkg::res_t   out_r, out_nxt;

  logic            acc;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [7:0]      wdata;
  logic [AW-1:0]   raddr;
  logic [CNTW-1:0] cm2;
  logic            line_ready;
  logic            is_bs;
  logic            go_bksp;
  logic            full;

  assign acc        = in_valid && in_ready;
  assign line_ready = (count_r != '0) && lz_r;
  assign is_bs      = (in_data.char_in == tlb_pkg::CH_BACKSPACE);
  assign go_bksp    = (in_data.action == tlb_pkg::ACT_APPEND) && is_bs && (count_r != '0);
  assign full       = (count_r == CNTW'(BUFFER_DEPTH));
  assign cm2        = count_r - CNTW'(2);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tlb_pkg::S_IDLE: begin
        if (acc && in_data.action == tlb_pkg::ACT_READ) begin
          state_nxt = tlb_pkg::S_READ;
        end else if (acc && go_bksp) begin
          state_nxt = tlb_pkg::S_BKSP;
        end
      end
      tlb_pkg::S_READ: state_nxt = tlb_pkg::S_IDLE;
      tlb_pkg::S_BKSP: state_nxt = tlb_pkg::S_IDLE;
      default:         state_nxt = tlb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == tlb_pkg::S_IDLE) && (!out_valid_r || out_ready);
    out_valid = out_valid_r;
    out_data  = out_r;
  end

  always_comb begin
    count_nxt     = count_r;
    lz_nxt        = lz_r;
    found_nxt     = found_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    we            = 1'b0;
    waddr         = count_r[AW-1:0];
    wdata         = in_data.char_in;
    raddr         = AW'(in_data.read_index);
    case (state_r)
      tlb_pkg::S_IDLE: begin
        if (acc) begin
          out_nxt.status     = 1'b0;
          out_nxt.read_found = 1'b0;
          out_nxt.read_byte  = 8'd0;
          case (in_data.action)
            tlb_pkg::ACT_APPEND: begin
              if (is_bs) begin
                if (count_r != '0) begin
                  count_nxt = count_r - CNTW'(1);
                  raddr     = cm2[AW-1:0];
                end
              end else if (in_data.char_in == tlb_pkg::CH_RETURN) begin
                count_nxt = count_r;
              end else if (in_data.char_in == tlb_pkg::CH_NEWLINE && count_r == '0) begin
                count_nxt = count_r;
              end else if (full) begin
                out_nxt.status = 1'b1;
              end else begin
                if (in_data.char_in == tlb_pkg::CH_NEWLINE) begin
                  wdata = tlb_pkg::CH_TERMINATOR;
                end
                we        = 1'b1;
                count_nxt = count_r + CNTW'(1);
                lz_nxt    = (wdata == tlb_pkg::CH_TERMINATOR);
              end
            end
            tlb_pkg::ACT_READ: begin
              found_nxt = line_ready && (XW'(in_data.read_index) < XW'(count_r));
            end
            tlb_pkg::ACT_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              count_nxt = count_r;
            end
          endcase
          out_nxt.line_ready = (count_nxt != '0) && lz_nxt;
          out_nxt.fill_count = 7'(count_nxt);
          out_valid_nxt      = !(in_data.action == tlb_pkg::ACT_READ) && !go_bksp;
        end
      end
      tlb_pkg::S_READ: begin
        out_nxt.status     = 1'b0;
        out_nxt.line_ready = line_ready;
        out_nxt.read_found = found_r;
        out_nxt.read_byte  = found_r ? rdata_r : 8'd0;
        out_nxt.fill_count = 7'(count_r);
        out_valid_nxt      = 1'b1;
      end
      tlb_pkg::S_BKSP: begin
        lz_nxt             = (rdata_r == tlb_pkg::CH_TERMINATOR);
        out_nxt.status     = 1'b0;
        out_nxt.line_ready = (count_r != '0) && (rdata_r == tlb_pkg::CH_TERMINATOR);
        out_nxt.read_found = 1'b0;
        out_nxt.read_byte  = 8'd0;
        out_nxt.fill_count = 7'(count_r);
        out_valid_nxt      = 1'b1;
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlb_pkg::S_IDLE;
      count_r     <= '0;
      lz_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      lz_r        <= lz_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    out_r   <= out_nxt;
  end

  a_wait_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != tlb_pkg::S_IDLE) |-> !out_valid_r)
    else $error("result register busy while a memory read is pending");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    XW'(count_r) <= XW'(BUFFER_DEPTH))
    else $error("fill count beyond buffer depth");

  a_read_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_data.action == tlb_pkg::ACT_READ) |=> (state_r == tlb_pkg::S_READ))
    else $error("read request did not wait for memory data");

  a_ready_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.line_ready) |-> (count_r != '0))
    else $error("line ready reported on an empty buffer");

endmodule

`default_nettype wire

### dv/terminal_line_buffer_test.sv
// ----------------------------------------------------------------------------
// Terminal line buffer testbench
// Feeds append, read, clear and unused requests through the input channel and
// checks every result against a line model kept in the bench. Short directed
// cases come first, then random line sessions with editing, reads and noise,
// under several sender and receiver idling mixes and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module terminal_line_buffer_test;

  localparam int DEPTH = tlb_pkg::DEFAULT_DEPTH;
  localparam int IW = $clog2(DEPTH);
  localparam int TOTAL_REQS = 950;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_AT = 400;
  localparam int HOLD_CYCLES = 80;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  tlb_pkg::req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tlb_pkg::res_t out_data;

  tlb_pkg::req_t req_q[$];
  tlb_pkg::res_t expected_q[$];
  logic [7:0] line_mem[DEPTH];
  int line_len = 0;
  int sent_cnt = 0;
  int rcv_cnt = 0;
  int total_cnt = 0;
  int fail_cnt = 0;
  int cycle_cnt = 0;
  int session_cnt = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  logic hold_on;

  terminal_line_buffer DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic line_is_ready();
    return line_len != 0 && line_mem[IW'(line_len - 1)] == tlb_pkg::CH_TERMINATOR;
  endfunction

  function automatic tlb_pkg::res_t predict_line(tlb_pkg::req_t r);
    tlb_pkg::res_t e;
    e = '0;
    case (r.action)
      tlb_pkg::ACT_APPEND: begin
        if (r.char_in == tlb_pkg::CH_BACKSPACE) begin
          if (line_len != 0) line_len--;
        end else if (r.char_in != tlb_pkg::CH_RETURN &&
                     !(r.char_in == tlb_pkg::CH_NEWLINE && line_len == 0)) begin
          if (line_len >= DEPTH) begin
            e.status = 1'b1;
          end else begin
            line_mem[IW'(line_len)] = (r.char_in == tlb_pkg::CH_NEWLINE) ?
                                      tlb_pkg::CH_TERMINATOR : r.char_in;
            line_len++;
          end
        end
      end
      tlb_pkg::ACT_READ: begin
        if (line_is_ready() && int'(r.read_index) < line_len) begin
          e.read_found = 1'b1;
          e.read_byte = line_mem[r.read_index];
        end
      end
      tlb_pkg::ACT_CLEAR: begin
        line_len = 0;
      end
      default: begin
      end
    endcase
    e.line_ready = line_is_ready();
    e.fill_count = 7'(line_len);
    return e;
  endfunction

  // Phases rotate every hundred requests: no idling, sender idle, receiver
  // stalling, then both lightly.
  function automatic int idle_pct(int cnt, logic rx_side);
    int p;
    p = (cnt / 100) % 4;
    if (p == 3) return 10;
    if (rx_side) return (p == 2) ? 47 : 0;
    return (p == 1) ? 47 : 0;
  endfunction

  task automatic check_result(tlb_pkg::res_t got);
    tlb_pkg::res_t e;
    if (expected_q.size() == 0) begin
      $error("result with no request outstanding: %h", got);
      fail_cnt++;
    end else begin
      e = expected_q.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, got.status);
        fail_cnt++;
      end
      if (got.line_ready !== e.line_ready) begin
        $error("line_ready: expected %0d, actual %0d", e.line_ready, got.line_ready);
        fail_cnt++;
      end
      if (got.read_found !== e.read_found) begin
        $error("read_found: expected %0d, actual %0d", e.read_found, got.read_found);
        fail_cnt++;
      end
      if (got.read_byte !== e.read_byte) begin
        $error("read_byte: expected %h, actual %h", e.read_byte, got.read_byte);
        fail_cnt++;
      end
      if (got.fill_count !== e.fill_count) begin
        $error("fill_count: expected %0d, actual %0d", e.fill_count, got.fill_count);
        fail_cnt++;
      end
    end
  endtask

  task automatic add_req(logic [1:0] act, logic [7:0] ch, logic [5:0] idx);
    tlb_pkg::req_t r;
    r.action = act;
    r.char_in = ch;
    r.read_index = idx;
    req_q.push_back(r);
  endtask

  // One line session: optional clear, an edited line, a newline most of the time,
  // then reads and sometimes noise. Every tenth session can run long enough to overflow the store.
  task automatic add_session();
    int len;
    int n;
    int sel;
    int top;
    logic [7:0] ch;
    if ($urandom_range(0, 3) != 0)
      add_req(tlb_pkg::ACT_CLEAR, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
    len = (session_cnt % 10 == 9) ? $urandom_range(55, 75) : $urandom_range(1, 12);
    for (int k = 0; k < len; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 75) ch = 8'($urandom_range(0, 255));
      else if (sel < 87) ch = tlb_pkg::CH_BACKSPACE;
      else if (sel < 92) ch = tlb_pkg::CH_RETURN;
      else if (sel < 96) ch = tlb_pkg::CH_TERMINATOR;
      else ch = tlb_pkg::CH_NEWLINE;
      add_req(tlb_pkg::ACT_APPEND, ch, 6'($urandom_range(0, 63)));
    end
    if ($urandom_range(0, 9) != 0)
      add_req(tlb_pkg::ACT_APPEND, tlb_pkg::CH_NEWLINE, 6'($urandom_range(0, 63)));
    top = (len + 1 > 63) ? 63 : len + 1;
    n = $urandom_range(1, 6);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 4) == 0)
        add_req(tlb_pkg::ACT_READ, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
      else
        add_req(tlb_pkg::ACT_READ, 8'($urandom_range(0, 255)), 6'($urandom_range(0, top)));
    end
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 4);
      for (int k = 0; k < n; k++)
        add_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                6'($urandom_range(0, 63)));
    end
    session_cnt++;
  endtask

  initial begin
    add_req(tlb_pkg::ACT_CLEAR, 8'hFF, 6'h3F);
    add_req(tlb_pkg::ACT_READ, 8'h00, 6'd0);
    add_req(tlb_pkg::ACT_APPEND, tlb_pkg::CH_BACKSPACE, 6'd0);
    add_req(tlb_pkg::ACT_APPEND, tlb_pkg::CH_NEWLINE, 6'd0);
    add_req(tlb_pkg::ACT_APPEND, tlb_pkg::CH_RETURN, 6'd0);
    add_req(ACT_UNUSED, 8'hFF, 6'h3F);
    add_req(tlb_pkg::ACT_APPEND, tlb_pkg::CH_TERMINATOR, 6'd0);
    add_req(tlb_pkg::ACT_READ, 8'h00, 6'd0);
    add_req(tlb_pkg::ACT_READ, 8'h00, 6'h3F);
    add_req(tlb_pkg::ACT_APPEND, 8'hFF, 6'd0);
    add_req(tlb_pkg::ACT_APPEND, 8'h41, 6'd0);
    add_req(tlb_pkg::ACT_READ, 8'h00, 6'd1);
    add_req(tlb_pkg::ACT_APPEND, tlb_pkg::CH_NEWLINE, 6'h3F);
    add_req(tlb_pkg::ACT_READ, 8'h00, 6'd0);
    add_req(tlb_pkg::ACT_READ, 8'h00, 6'd1);
    add_req(tlb_pkg::ACT_READ, 8'h00, 6'd2);
    add_req(tlb_pkg::ACT_READ, 8'h00, 6'd3);
    add_req(tlb_pkg::ACT_APPEND, tlb_pkg::CH_BACKSPACE, 6'd0);
    add_req(tlb_pkg::ACT_READ, 8'h00, 6'd0);
    add_req(tlb_pkg::ACT_APPEND, 8'h7F, 6'd0);
    add_req(tlb_pkg::ACT_APPEND, tlb_pkg::CH_NEWLINE, 6'd0);
    add_req(tlb_pkg::ACT_READ, 8'hFF, 6'd3);
    add_req(tlb_pkg::ACT_CLEAR, 8'h00, 6'd0);
    add_req(tlb_pkg::ACT_READ, 8'h00, 6'd0);
    while (req_q.size() < TOTAL_REQS) add_session();
    total_cnt = req_q.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (rcv_cnt < total_cnt) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d results never arrived", expected_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("terminal_line_buffer_test OK");
    end else begin
      $display("terminal_line_buffer_test NOT OK");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_q.push_back(predict_line(in_data));
        sent_cnt <= sent_cnt + 1;
      end
      if (!in_valid || in_ready) begin
        if (req_q.size() != 0 && $urandom_range(0, 99) >= idle_pct(sent_cnt, 1'b0)) begin
          in_valid <= 1'b1;
          in_data <= req_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && rcv_cnt >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  assign hold_on = (hold_left != 0);

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_result(out_data);
        rcv_cnt <= rcv_cnt + 1;
      end
      out_ready <= !hold_on && ($urandom_range(0, 99) >= idle_pct(rcv_cnt, 1'b1));
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("terminal_line_buffer_test NOT OK");
      $finish;
    end
  end

endmodule

### filelist.f
sv/tlb_pkg.sv
sv/terminal_line_buffer.sv
dv/terminal_line_buffer_test.sv
